// ===== src/bfsp_pkg.sv =====
// Shared types and constants for the Bellman-Ford shortest paths unit.
// No dependencies; used by every other file of the block.
package bfsp_pkg;

    localparam int VID_W  = 6;
    localparam int DIST_W = 32;
    localparam int VCNT_W = 7;

    localparam logic [VCNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fff_ffff;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

    // input action codes
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_RUN    = 2'd2;

    // configuration register index
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef struct packed {
        logic append;
        logic clear;
    } edge_cmd_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DIST_W-1:0] cand;
    } relax_result_t;

endpackage

// ===== src/bfsp_if.sv =====
// Valid/ready channel interfaces for input items and per-vertex results.
// Depends on bfsp_pkg for field widths.
interface bfsp_item_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic [bfsp_pkg::VID_W-1:0]    edge_from;
    logic [bfsp_pkg::VID_W-1:0]    edge_to;
    logic signed [15:0]            edge_weight;
    logic [bfsp_pkg::VID_W-1:0]    source_vertex;

    modport source (output valid, action, edge_from, edge_to, edge_weight, source_vertex,
                    input ready);
    modport sink   (input valid, action, edge_from, edge_to, edge_weight, source_vertex,
                    output ready);
endinterface

interface bfsp_result_if;
    logic                              valid;
    logic                              ready;
    logic [bfsp_pkg::VID_W-1:0]        vertex;
    logic signed [bfsp_pkg::DIST_W-1:0] distance;
    logic                              reachable;
    logic                              negative_cycle;
    logic                              edge_overflow;
    logic                              last;

    modport source (output valid, vertex, distance, reachable, negative_cycle,
                    edge_overflow, last, input ready);
    modport sink   (input valid, vertex, distance, reachable, negative_cycle,
                    edge_overflow, last, output ready);
endinterface

// ===== src/bfsp_edge_store.sv =====
// Edge list memory with fill count and overflow flag.
// Depends on bfsp_pkg (edge_cmd_t, VID_W).
module bfsp_edge_store #(
    parameter int  MAX_EDGES   = 1024,
    parameter int  WEIGHT_BITS = 16,
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int ETW = $clog2(MAX_EDGES + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bfsp_pkg::edge_cmd_t          cmd,
    input  logic [bfsp_pkg::VID_W-1:0]   wr_tail,
    input  logic [bfsp_pkg::VID_W-1:0]   wr_head,
    input  logic [WEIGHT_BITS-1:0]       wr_weight,
    input  logic [EAW-1:0]               rd_addr,
    output logic [bfsp_pkg::VID_W-1:0]   rd_tail,
    output logic [bfsp_pkg::VID_W-1:0]   rd_head,
    output logic [WEIGHT_BITS-1:0]       rd_weight,
    output logic [ETW-1:0]               total,
    output logic                         overflow
);

    localparam int ENTRY_W = 2 * bfsp_pkg::VID_W + WEIGHT_BITS;

    logic [ENTRY_W-1:0] mem [MAX_EDGES];
    logic [ENTRY_W-1:0] rd_reg;
    logic [ETW-1:0]     total_reg;
    logic [ETW-1:0]     total_next;
    logic               overflow_reg;
    logic               overflow_next;
    logic               has_room;
    logic               do_write;

    assign has_room = (total_reg < ETW'(MAX_EDGES));
    assign do_write = cmd.append && has_room;

    always_comb
    begin
        total_next    = total_reg;
        overflow_next = overflow_reg;
        if (cmd.clear)
        begin
            total_next    = '0;
            overflow_next = 1'b0;
        end
        else if (cmd.append)
        begin
            if (has_room)
                total_next = total_reg + ETW'(1);
            else
                overflow_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            total_reg    <= total_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[total_reg[EAW-1:0]] <= {wr_tail, wr_head, wr_weight};
        rd_reg <= mem[rd_addr];
    end

    assign rd_tail   = rd_reg[ENTRY_W-1 -: bfsp_pkg::VID_W];
    assign rd_head   = rd_reg[WEIGHT_BITS +: bfsp_pkg::VID_W];
    assign rd_weight = rd_reg[WEIGHT_BITS-1:0];
    assign total     = total_reg;
    assign overflow  = overflow_reg;

endmodule

// ===== src/bfsp_dist_store.sv =====
// Distance memory: two registered read ports, one write port.
// Depends on bfsp_pkg (DIST_W).
module bfsp_dist_store #(
    parameter int  MAX_VERTICES = 64,
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
    input  logic                               clk,
    input  logic [VW-1:0]                      ra_addr,
    input  logic [VW-1:0]                      rb_addr,
    output logic signed [bfsp_pkg::DIST_W-1:0] ra_data,
    output logic signed [bfsp_pkg::DIST_W-1:0] rb_data,
    input  logic                               we,
    input  logic [VW-1:0]                      wr_addr,
    input  logic signed [bfsp_pkg::DIST_W-1:0] wr_data
);

    logic signed [bfsp_pkg::DIST_W-1:0] mem [MAX_VERTICES];
    logic signed [bfsp_pkg::DIST_W-1:0] ra_reg;
    logic signed [bfsp_pkg::DIST_W-1:0] rb_reg;

    // read returns the old value on a same-address write; caller forwards
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        ra_reg <= mem[ra_addr];
        rb_reg <= mem[rb_addr];
    end

    assign ra_data = ra_reg;
    assign rb_data = rb_reg;

endmodule

// ===== src/bfsp_relax.sv =====
// Edge relaxation: forwarding of the last write, saturating add, compare.
// Depends on bfsp_pkg (relax_result_t, DIST_MAX, DIST_MIN).
module bfsp_relax #(
    parameter int  MAX_VERTICES = 64,
    parameter int  WEIGHT_BITS  = 16,
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
    input  logic [VW-1:0]                      tail_addr,
    input  logic [VW-1:0]                      head_addr,
    input  logic                               tail_reached,
    input  logic                               head_reached,
    input  logic signed [bfsp_pkg::DIST_W-1:0] d_tail,
    input  logic signed [bfsp_pkg::DIST_W-1:0] d_head,
    input  logic [WEIGHT_BITS-1:0]             weight,
    input  logic                               fwd_valid,
    input  logic [VW-1:0]                      fwd_addr,
    input  logic signed [bfsp_pkg::DIST_W-1:0] fwd_data,
    output bfsp_pkg::relax_result_t            result
);

    logic signed [bfsp_pkg::DIST_W-1:0] dt;
    logic signed [bfsp_pkg::DIST_W-1:0] dh;
    logic signed [bfsp_pkg::DIST_W-1:0] w_ext;
    logic signed [bfsp_pkg::DIST_W:0]   sum;
    logic signed [bfsp_pkg::DIST_W-1:0] cand;

    always_comb
    begin
        // the memory read missed the write made in the previous cycle
        dt    = (fwd_valid && fwd_addr == tail_addr) ? fwd_data : d_tail;
        dh    = (fwd_valid && fwd_addr == head_addr) ? fwd_data : d_head;
        w_ext = bfsp_pkg::DIST_W'(signed'(weight));
        sum   = {dt[bfsp_pkg::DIST_W-1], dt} + {w_ext[bfsp_pkg::DIST_W-1], w_ext};
        if (sum[bfsp_pkg::DIST_W] != sum[bfsp_pkg::DIST_W-1])
            cand = sum[bfsp_pkg::DIST_W] ? bfsp_pkg::DIST_MIN : bfsp_pkg::DIST_MAX;
        else
            cand = sum[bfsp_pkg::DIST_W-1:0];
        result.cand = cand;
        result.hit  = tail_reached && (!head_reached || (cand < dh));
    end

endmodule

// ===== src/bellman_ford_shortest_paths_unit.sv =====
// Bellman-Ford shortest paths unit. A run makes n-1 passes (n active vertices), each
// scanning the edge memory once per tail vertex, one edge a cycle; a final check pass
// scans it once more, then results go out one per vertex, each held until taken. With
// no edges or an out-of-range source the sweeps are skipped. Reset (rst_n low, async)
// empties the edge list, clears overflow and reached marks and sets vertex_count to 64.
module bellman_ford_shortest_paths_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bfsp_item_if.sink            item,
    bfsp_result_if.source        result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int VID = bfsp_pkg::VID_W;
    localparam int DW  = bfsp_pkg::DIST_W;
    localparam int CW  = bfsp_pkg::VCNT_W;

    // configuration
    logic [CW-1:0] vertex_count_reg;
    logic [CW-1:0] n_act;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == bfsp_pkg::REG_VERTEX_COUNT);
    assign prdata = (paddr[2] == bfsp_pkg::REG_VERTEX_COUNT) ? 32'(vertex_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vertex_count_reg <= bfsp_pkg::VERTEX_COUNT_RESET;
        else if (cfg_wr)
            vertex_count_reg <= pwdata[CW-1:0];
    end

    always_comb
    begin
        if (vertex_count_reg < CW'(2))
            n_act = CW'(2);
        else if (vertex_count_reg > CW'(MAX_VERTICES))
            n_act = CW'(MAX_VERTICES);
        else
            n_act = vertex_count_reg;
    end

    // control state
    bfsp_pkg::state_t state_reg, state_next;
    logic [VID-1:0]   u_reg, u_next;
    logic [VID-1:0]   pass_reg, pass_next;
    logic [EAW-1:0]   k_reg, k_next;
    logic             check_reg, check_next;
    logic [VID-1:0]   src_reg;
    logic             issue;
    logic             init_wr;
    logic             res_load;
    logic             src_ok;
    logic             item_acc;

    bfsp_pkg::edge_cmd_t ecmd;
    logic [VID-1:0]      e_tail;
    logic [VID-1:0]      e_head;
    logic [WEIGHT_BITS-1:0] e_weight;
    logic [ETW-1:0]      edge_total;
    logic                overflow;

    // pipeline
    logic                   s1_valid_reg;
    logic                   s1_check_reg;
    logic [VID-1:0]         s1_u_reg;
    logic                   s1_pass;
    logic                   s2_valid_reg;
    logic                   s2_check_reg;
    logic [VID-1:0]         s2_tail_reg;
    logic [VID-1:0]         s2_head_reg;
    logic [WEIGHT_BITS-1:0] s2_weight_reg;
    logic                   fwd_valid_reg;
    logic [VW-1:0]          fwd_addr_reg;
    logic signed [DW-1:0]   fwd_data_reg;

    logic [MAX_VERTICES-1:0] reached_reg;
    logic                    neg_reg;
    bfsp_pkg::relax_result_t rr;
    logic                    apply_wr;

    logic [VW-1:0]          ra_addr;
    logic signed [DW-1:0]   ra_data;
    logic signed [DW-1:0]   rb_data;
    logic                   dist_we;
    logic [VW-1:0]          dist_waddr;
    logic signed [DW-1:0]   dist_wdata;

    // result register
    logic                   res_valid_reg;
    logic [VID-1:0]         res_vertex_reg;
    logic signed [DW-1:0]   res_distance_reg;
    logic                   res_reachable_reg;
    logic                   res_neg_reg;
    logic                   res_ovf_reg;
    logic                   res_last_reg;

    assign item.ready  = (state_reg == bfsp_pkg::ST_IDLE);
    assign item_acc    = item.valid && item.ready;
    assign ecmd.append = item_acc && (item.action == bfsp_pkg::ACT_APPEND);
    assign ecmd.clear  = item_acc && (item.action == bfsp_pkg::ACT_CLEAR);
    assign src_ok      = ({1'b0, src_reg} < n_act);

    bfsp_edge_store #(
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_edges (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ecmd),
        .wr_tail   (item.edge_from),
        .wr_head   (item.edge_to),
        .wr_weight (WEIGHT_BITS'(unsigned'(item.edge_weight))),
        .rd_addr   (k_reg),
        .rd_tail   (e_tail),
        .rd_head   (e_head),
        .rd_weight (e_weight),
        .total     (edge_total),
        .overflow  (overflow)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfsp_pkg::ST_IDLE;
            u_reg     <= '0;
            pass_reg  <= '0;
            k_reg     <= '0;
            check_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            u_reg     <= u_next;
            pass_reg  <= pass_next;
            k_reg     <= k_next;
            check_reg <= check_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        u_next     = u_reg;
        pass_next  = pass_reg;
        k_next     = k_reg;
        check_next = check_reg;
        issue      = 1'b0;
        init_wr    = 1'b0;
        res_load   = 1'b0;
        case (state_reg)
            bfsp_pkg::ST_IDLE:
            begin
                if (item_acc && item.action == bfsp_pkg::ACT_RUN)
                    state_next = bfsp_pkg::ST_INIT;
            end
            bfsp_pkg::ST_INIT:
            begin
                u_next     = '0;
                pass_next  = '0;
                k_next     = '0;
                check_next = 1'b0;
                init_wr    = src_ok;
                if (src_ok && edge_total != '0)
                    state_next = bfsp_pkg::ST_SWEEP;
                else
                    state_next = bfsp_pkg::ST_DRAIN;
            end
            bfsp_pkg::ST_SWEEP:
            begin
                issue = 1'b1;
                if (ETW'(k_reg) == edge_total - ETW'(1))
                begin
                    k_next = '0;
                    if (check_reg)
                        state_next = bfsp_pkg::ST_DRAIN;
                    else if ({1'b0, u_reg} == n_act - CW'(1))
                    begin
                        u_next = '0;
                        if ({1'b0, pass_reg} == n_act - CW'(2))
                            check_next = 1'b1;
                        else
                            pass_next = pass_reg + VID'(1);
                    end
                    else
                        u_next = u_reg + VID'(1);
                end
                else
                    k_next = k_reg + EAW'(1);
            end
            bfsp_pkg::ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    u_next     = '0;
                    state_next = bfsp_pkg::ST_EMIT_RD;
                end
            end
            bfsp_pkg::ST_EMIT_RD:
            begin
                state_next = bfsp_pkg::ST_EMIT_LD;
            end
            bfsp_pkg::ST_EMIT_LD:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_load = 1'b1;
                    if ({1'b0, u_reg} == n_act - CW'(1))
                        state_next = bfsp_pkg::ST_IDLE;
                    else
                    begin
                        u_next     = u_reg + VID'(1);
                        state_next = bfsp_pkg::ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = bfsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
            src_reg <= item.source_vertex;
    end

    // stage 1: edge word back from memory; filter and fetch distances
    assign s1_pass = ({1'b0, e_head} < n_act) &&
                     (s1_check_reg ? ({1'b0, e_tail} < n_act) : (e_tail == s1_u_reg));

    assign ra_addr = (state_reg == bfsp_pkg::ST_EMIT_RD || state_reg == bfsp_pkg::ST_EMIT_LD)
                     ? u_reg[VW-1:0] : e_tail[VW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg && s1_pass;
            fwd_valid_reg <= apply_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_check_reg  <= check_reg;
        s1_u_reg      <= u_reg;
        s2_check_reg  <= s1_check_reg;
        s2_tail_reg   <= e_tail;
        s2_head_reg   <= e_head;
        s2_weight_reg <= e_weight;
        fwd_addr_reg  <= s2_head_reg[VW-1:0];
        fwd_data_reg  <= rr.cand;
    end

    bfsp_dist_store #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dist (
        .clk     (clk),
        .ra_addr (ra_addr),
        .rb_addr (e_head[VW-1:0]),
        .ra_data (ra_data),
        .rb_data (rb_data),
        .we      (dist_we),
        .wr_addr (dist_waddr),
        .wr_data (dist_wdata)
    );

    // stage 2: relax and write back
    bfsp_relax #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_relax (
        .tail_addr    (s2_tail_reg[VW-1:0]),
        .head_addr    (s2_head_reg[VW-1:0]),
        .tail_reached (reached_reg[s2_tail_reg[VW-1:0]]),
        .head_reached (reached_reg[s2_head_reg[VW-1:0]]),
        .d_tail       (ra_data),
        .d_head       (rb_data),
        .weight       (s2_weight_reg),
        .fwd_valid    (fwd_valid_reg),
        .fwd_addr     (fwd_addr_reg),
        .fwd_data     (fwd_data_reg),
        .result       (rr)
    );

    assign apply_wr   = s2_valid_reg && !s2_check_reg && rr.hit;
    assign dist_we    = apply_wr || init_wr;
    assign dist_waddr = init_wr ? src_reg[VW-1:0] : s2_head_reg[VW-1:0];
    assign dist_wdata = init_wr ? '0 : rr.cand;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg <= '0;
            neg_reg     <= 1'b0;
        end
        else if (state_reg == bfsp_pkg::ST_INIT)
        begin
            reached_reg <= '0;
            if (src_ok)
                reached_reg[src_reg[VW-1:0]] <= 1'b1;
            neg_reg <= 1'b0;
        end
        else
        begin
            if (apply_wr)
                reached_reg[s2_head_reg[VW-1:0]] <= 1'b1;
            if (s2_valid_reg && s2_check_reg && rr.hit)
                neg_reg <= 1'b1;
        end
    end

    // result register: a transaction is held until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_vertex_reg    <= u_reg;
            res_distance_reg  <= reached_reg[u_reg[VW-1:0]] ? ra_data : '0;
            res_reachable_reg <= reached_reg[u_reg[VW-1:0]];
            res_neg_reg       <= neg_reg;
            res_ovf_reg       <= overflow;
            res_last_reg      <= ({1'b0, u_reg} == n_act - CW'(1));
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.vertex         = res_vertex_reg;
    assign result.distance       = res_distance_reg;
    assign result.reachable      = res_reachable_reg;
    assign result.negative_cycle = res_neg_reg;
    assign result.edge_overflow  = res_ovf_reg;
    assign result.last           = res_last_reg;

endmodule

// ===== dv/bellman_ford_shortest_paths_unit_test.sv =====
// Testbench for the Bellman-Ford shortest paths unit: drives append/clear/run items,
// predicts per-vertex results with its own path solver and checks every result.
// Depends on bfsp_pkg, the bfsp item/result interfaces and the unit itself.
module bellman_ford_shortest_paths_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VERTICES   = 64;
    localparam int NUM_EDGE_SLOTS = 1024;
    localparam int LONG_HOLD      = 600;
    localparam int IDLE_SETTLE    = 8;
    localparam int RUN_LIMIT_NS   = 20_000_000;

    // action code the unit must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]                   action;
        logic [bfsp_pkg::VID_W-1:0]   tail;
        logic [bfsp_pkg::VID_W-1:0]   head;
        logic signed [15:0]           weight;
        logic [bfsp_pkg::VID_W-1:0]   src;
    } graph_op_t;

    typedef struct {
        logic [bfsp_pkg::VID_W-1:0]         vertex;
        logic signed [bfsp_pkg::DIST_W-1:0] distance;
        logic                               reachable;
        logic                               negative_cycle;
        logic                               edge_overflow;
        logic                               last;
    } vertex_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bfsp_item_if   item_ch ();
    bfsp_result_if result_ch ();

    bellman_ford_shortest_paths_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // stimulus side
    graph_op_t      pending_ops[$];
    int             ops_queued = 0;
    int             ops_accepted = 0;
    int             gen_stored = 0;
    int             gen_items = 0;
    graph_op_t      next_op;
    graph_op_t      taken_op;
    bit             item_taken = 1'b0;
    int             send_gap = 0;
    int             send_calm = 0;
    int             recv_gap = 0;
    int             recv_calm = 0;
    int             hold_left = 0;
    int             hold_requests = 0;
    int             hold_served = 0;
    int             mismatch_count = 0;

    // predictor state
    logic [6:0]                 vertex_count_cfg = bfsp_pkg::VERTEX_COUNT_RESET;
    logic [bfsp_pkg::VID_W-1:0] edge_tail[NUM_EDGE_SLOTS];
    logic [bfsp_pkg::VID_W-1:0] edge_head[NUM_EDGE_SLOTS];
    logic signed [15:0]         edge_wt[NUM_EDGE_SLOTS];
    int                         edges_held = 0;
    bit                         dropped_flag = 1'b0;
    int                         path_dist[NUM_VERTICES];
    bit                         path_reached[NUM_VERTICES];
    int                         scan_order[$];
    vertex_result_t             awaited_results[$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int active_n(logic [6:0] vc);
        if (vc < 2) return 2;
        if (vc > NUM_VERTICES) return NUM_VERTICES;
        return int'(vc);
    endfunction

    function automatic int clamp_sum(int a, logic signed [15:0] w);
        longint s;
        s = longint'(a) + longint'(w);
        if (s > longint'(bfsp_pkg::DIST_MAX)) return int'(bfsp_pkg::DIST_MAX);
        if (s < longint'(bfsp_pkg::DIST_MIN)) return int'(bfsp_pkg::DIST_MIN);
        return int'(s);
    endfunction

    // one pass over the ordered usable edges; edges out of unreached tails are skipped
    function automatic bit relax_all(bit commit);
        int t;
        int h;
        int cand;
        bit any;
        any = 1'b0;
        foreach (scan_order[i])
        begin
            t = edge_tail[scan_order[i]];
            h = edge_head[scan_order[i]];
            if (path_reached[t])
            begin
                cand = clamp_sum(path_dist[t], edge_wt[scan_order[i]]);
                if (!path_reached[h] || cand < path_dist[h])
                begin
                    any = 1'b1;
                    if (!commit) return 1'b1;
                    path_dist[h] = cand;
                    path_reached[h] = 1'b1;
                end
            end
        end
        return any;
    endfunction

    task automatic predict_run(logic [bfsp_pkg::VID_W-1:0] src);
        int n;
        int u;
        int k;
        bit neg;
        vertex_result_t r;
        n = active_n(vertex_count_cfg);
        neg = 1'b0;
        // tails ascending, load order within a tail; edges touching vertices >= n drop out
        scan_order.delete();
        for (u = 0; u < n; u++)
            for (k = 0; k < edges_held; k++)
                if (edge_tail[k] == u && edge_head[k] < n)
                    scan_order.push_back(k);
        for (u = 0; u < NUM_VERTICES; u++)
        begin
            path_dist[u] = 0;
            path_reached[u] = 1'b0;
        end
        if (src < n)
        begin
            path_reached[src] = 1'b1;
            repeat (n - 1) void'(relax_all(1'b1));
            neg = relax_all(1'b0);
        end
        for (u = 0; u < n; u++)
        begin
            r.vertex = bfsp_pkg::VID_W'(u);
            r.distance = path_reached[u] ? path_dist[u] : 0;
            r.reachable = path_reached[u];
            r.negative_cycle = neg;
            r.edge_overflow = dropped_flag;
            r.last = (u == n - 1);
            awaited_results.push_back(r);
        end
    endtask

    task automatic apply_graph_op(graph_op_t op);
        case (op.action)
            bfsp_pkg::ACT_APPEND:
            begin
                if (edges_held < NUM_EDGE_SLOTS)
                begin
                    edge_tail[edges_held] = op.tail;
                    edge_head[edges_held] = op.head;
                    edge_wt[edges_held] = op.weight;
                    edges_held++;
                end
                else
                    dropped_flag = 1'b1;
            end
            bfsp_pkg::ACT_CLEAR:
            begin
                edges_held = 0;
                dropped_flag = 1'b0;
            end
            bfsp_pkg::ACT_RUN:
                predict_run(op.src);
            default:
                ;
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
            mismatch_count++;
        end
    endtask

    task automatic check_vertex_result();
        vertex_result_t want;
        if (awaited_results.size() == 0)
        begin
            $error("result for vertex %0d arrived with nothing outstanding", result_ch.vertex);
            mismatch_count++;
        end
        else
        begin
            want = awaited_results.pop_front();
            check_field("vertex", 32'(want.vertex), 32'(result_ch.vertex));
            check_field("distance", want.distance, result_ch.distance);
            check_field("reachable", 32'(want.reachable), 32'(result_ch.reachable));
            check_field("negative_cycle", 32'(want.negative_cycle),
                        32'(result_ch.negative_cycle));
            check_field("edge_overflow", 32'(want.edge_overflow),
                        32'(result_ch.edge_overflow));
            check_field("last", 32'(want.last), 32'(result_ch.last));
        end
    endtask

    // mostly no idling, some short gaps, a few long ones, now and then a calm stretch
    function automatic int draw_idle(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 70) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(12, 48);
    endfunction

    // item driver
    always @(negedge clk)
    begin
        if (rst_n && !(item_ch.valid && !item_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_ch.valid <= 1'b0;
            end
            else if (pending_ops.size() != 0)
            begin
                next_op = pending_ops.pop_front();
                item_ch.action <= next_op.action;
                item_ch.edge_from <= next_op.tail;
                item_ch.edge_to <= next_op.head;
                item_ch.edge_weight <= next_op.weight;
                item_ch.source_vertex <= next_op.src;
                item_ch.valid <= 1'b1;
                send_gap = draw_idle(send_calm);
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            recv_gap = draw_idle(recv_calm);
            result_ch.ready <= (recv_gap == 0);
            if (recv_gap > 0) recv_gap--;
        end
    end

    // monitor: predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            item_taken <= item_ch.valid && item_ch.ready;
            if (item_ch.valid && item_ch.ready)
            begin
                taken_op.action = item_ch.action;
                taken_op.tail = item_ch.edge_from;
                taken_op.head = item_ch.edge_to;
                taken_op.weight = item_ch.edge_weight;
                taken_op.src = item_ch.source_vertex;
                apply_graph_op(taken_op);
                ops_accepted++;
            end
            if (result_ch.valid && result_ch.ready)
                check_vertex_result();
        end
    end

    function automatic graph_op_t make_op(logic [1:0] action, int tail, int head, int weight,
                                          int src);
        graph_op_t op;
        op.action = action;
        op.tail = bfsp_pkg::VID_W'(tail);
        op.head = bfsp_pkg::VID_W'(head);
        op.weight = 16'(weight);
        op.src = bfsp_pkg::VID_W'(src);
        return op;
    endfunction

    function automatic graph_op_t random_op();
        graph_op_t op;
        op.action = 2'($urandom_range(0, 3));
        op.tail = bfsp_pkg::VID_W'($urandom);
        op.head = bfsp_pkg::VID_W'($urandom);
        op.weight = 16'($urandom);
        op.src = bfsp_pkg::VID_W'($urandom);
        return op;
    endfunction

    // small weights around zero so negative cycles show up now and then
    function automatic logic signed [15:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 16'($urandom_range(0, 60)) - 16'sd10;
        if (r < 85) return 16'($urandom_range(0, 2000));
        return 16'($urandom);
    endfunction

    function automatic logic [bfsp_pkg::VID_W-1:0] pick_vertex(int n);
        if ($urandom_range(0, 9) == 0) return bfsp_pkg::VID_W'($urandom);
        return bfsp_pkg::VID_W'($urandom_range(0, n - 1));
    endfunction

    task automatic queue_op(graph_op_t op);
        if (op.action == bfsp_pkg::ACT_APPEND && gen_stored < NUM_EDGE_SLOTS) gen_stored++;
        if (op.action == bfsp_pkg::ACT_CLEAR) gen_stored = 0;
        if (op.action != ACT_UNUSED) gen_items++;
        pending_ops.push_back(op);
        ops_queued++;
    endtask

    // mostly a well-formed graph plus a run, sometimes raw noise; cap bounds run length
    task automatic queue_random_group(int n, int max_new, int cap);
        graph_op_t op;
        int count;
        count = $urandom_range(1, max_new);
        if ($urandom_range(0, 99) < 85)
        begin
            if (gen_stored + count > cap || $urandom_range(0, 2) == 0)
            begin
                op = random_op();
                op.action = bfsp_pkg::ACT_CLEAR;
                queue_op(op);
            end
            repeat (count)
            begin
                op = random_op();
                op.action = bfsp_pkg::ACT_APPEND;
                op.tail = pick_vertex(n);
                op.head = pick_vertex(n);
                op.weight = pick_weight();
                queue_op(op);
            end
            op = random_op();
            op.action = bfsp_pkg::ACT_RUN;
            op.src = pick_vertex(n);
            queue_op(op);
        end
        else
        begin
            repeat (count)
            begin
                op = random_op();
                if (op.action == bfsp_pkg::ACT_APPEND && gen_stored >= cap)
                    op.action = bfsp_pkg::ACT_CLEAR;
                queue_op(op);
            end
        end
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (ops_accepted != ops_queued || awaited_results.size() != 0);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic write_vertex_count(logic [6:0] value);
        logic [2:0] addr;
        addr = {bfsp_pkg::REG_VERTEX_COUNT, 2'b00};
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        vertex_count_cfg = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== 32'(value))
        begin
            $error("vertex_count read-back mismatch: expected %0d, actual %0d", value, prdata);
            mismatch_count++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        int vc_plan[11];
        int n;
        int cap;
        int budget_end;
        bit paused;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.action = bfsp_pkg::ACT_APPEND;
        item_ch.edge_from = '0;
        item_ch.edge_to = '0;
        item_ch.edge_weight = '0;
        item_ch.source_vertex = '0;
        result_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset vertex count: empty store, weight extremes, unreached tail, ignored action
        queue_op(make_op(bfsp_pkg::ACT_RUN, 0, 0, 0, 0));
        queue_op(make_op(bfsp_pkg::ACT_APPEND, 0, 1, 32767, 0));
        queue_op(make_op(bfsp_pkg::ACT_APPEND, 1, 2, -32768, 0));
        queue_op(make_op(bfsp_pkg::ACT_APPEND, 2, 63, -1, 0));
        queue_op(make_op(bfsp_pkg::ACT_APPEND, 63, 5, 0, 0));
        queue_op(make_op(bfsp_pkg::ACT_APPEND, 7, 8, 100, 0));
        queue_op(make_op(bfsp_pkg::ACT_RUN, 0, 0, 0, 0));
        queue_op(make_op(bfsp_pkg::ACT_RUN, 63, 63, -1, 63));
        queue_op(make_op(ACT_UNUSED, 63, 63, -1, 63));
        queue_op(make_op(bfsp_pkg::ACT_CLEAR, 0, 0, 0, 0));
        queue_op(make_op(bfsp_pkg::ACT_APPEND, 3, 4, -5, 0));
        queue_op(make_op(bfsp_pkg::ACT_APPEND, 4, 3, 2, 0));
        queue_op(make_op(bfsp_pkg::ACT_APPEND, 0, 3, 7, 0));
        queue_op(make_op(bfsp_pkg::ACT_RUN, 0, 0, 0, 0));
        queue_op(make_op(bfsp_pkg::ACT_RUN, 0, 0, 0, 5));
        wait_quiet();

        // vertex count below the minimum acts as 2; endpoint 9 and source 9 fall outside
        write_vertex_count(7'd0);
        queue_op(make_op(bfsp_pkg::ACT_CLEAR, 0, 0, 0, 0));
        queue_op(make_op(bfsp_pkg::ACT_APPEND, 0, 1, -3, 0));
        queue_op(make_op(bfsp_pkg::ACT_APPEND, 1, 0, 3, 0));
        queue_op(make_op(bfsp_pkg::ACT_APPEND, 0, 9, 1, 0));
        queue_op(make_op(bfsp_pkg::ACT_APPEND, 9, 1, -50, 0));
        queue_op(make_op(bfsp_pkg::ACT_RUN, 0, 0, 0, 0));
        queue_op(make_op(bfsp_pkg::ACT_RUN, 0, 0, 0, 1));
        queue_op(make_op(bfsp_pkg::ACT_RUN, 0, 0, 0, 9));
        queue_op(make_op(bfsp_pkg::ACT_APPEND, 1, 1, -1, 0));
        queue_op(make_op(bfsp_pkg::ACT_RUN, 0, 0, 0, 0));
        wait_quiet();

        // above the maximum acts as 64: the stored out-of-range edges now count
        write_vertex_count(7'd127);
        queue_op(make_op(bfsp_pkg::ACT_RUN, 0, 0, 0, 0));
        queue_op(make_op(bfsp_pkg::ACT_RUN, 0, 0, 0, 9));
        queue_op(make_op(bfsp_pkg::ACT_RUN, 0, 0, 0, 63));
        wait_quiet();

        // random phases; large graphs keep few edges since run time grows fast with both vertex and edge count
        vc_plan = '{8, 3, 64, 1, 13, 127, 5, 2, 40, 65, 10};
        gen_items = 0;
        paused = 1'b0;
        foreach (vc_plan[p])
        begin
            wait_quiet();
            write_vertex_count(7'(vc_plan[p]));
            n = active_n(7'(vc_plan[p]));
            cap = (n >= 40) ? 4 : 24;
            if (gen_stored > cap) queue_op(make_op(bfsp_pkg::ACT_CLEAR, 0, 0, 0, 0));
            // receiver holds off while items keep coming, so the unit backs up
            if (p == 1) hold_requests++;
            budget_end = gen_items + ((n >= 40) ? 12 : 16);
            while (gen_items < budget_end)
            begin
                if (p == 4 && !paused && gen_items >= budget_end - 12)
                begin
                    wait_quiet();
                    paused = 1'b1;
                end
                queue_random_group(n, (n >= 40) ? 3 : 10, cap);
            end
        end

        wait_quiet();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
